>>> design/pmp_pkg.sv
// ----------------------------------------------------------------------------
// pmp_pkg
// Shared types, widths and helpers for the polygon mass-property block.
// ----------------------------------------------------------------------------
package pmp_pkg;

  localparam int COORD_W          = 16;
  localparam int AREA_W           = 48;
  localparam int SUM_W            = 64;
  localparam int MUL_A_W          = 18;
  localparam int MUL_B_W          = 34;
  localparam int MUL_P_W          = MUL_A_W + MUL_B_W;
  localparam int DEN_W            = AREA_W + 2;
  localparam int CENT_W           = 16;
  localparam int DEF_MAX_VERTICES = 256;

  // result status codes
  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_ZERO = 2'd1;
  localparam logic [1:0] STATUS_SAT  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EDGE,
    ST_DIV3,
    ST_INER,
    ST_CX,
    ST_CY,
    ST_DONE
  } st_t;

  typedef struct packed {
    logic                    ovf;
    logic signed [SUM_W-1:0] val;
  } sat_res_t;

  // Saturating signed add on the 64-bit accumulators
  function automatic sat_res_t sat_add64(input logic signed [SUM_W-1:0] a,
                                         input logic signed [SUM_W-1:0] b);
    logic signed [SUM_W:0] s;
    sat_res_t              r;
    s     = {a[SUM_W-1], a} + {b[SUM_W-1], b};
    r.ovf = s[SUM_W] ^ s[SUM_W-1];
    if (r.ovf) begin
      r.val = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      r.val = s[SUM_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> design/pmp_cdiv.sv
// ----------------------------------------------------------------------------
// pmp_cdiv
// Restoring divider for the centroid: signed numerator over unsigned
// denominator, truncated toward zero, saturated to a signed 16-bit result.
// ----------------------------------------------------------------------------
module pmp_cdiv (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [pmp_pkg::SUM_W-1:0]   num,
  input  logic        [pmp_pkg::DEN_W-1:0]   den,
  output logic                               done,
  output logic signed [pmp_pkg::CENT_W-1:0]  quo,
  output logic                               sat
);
  import pmp_pkg::*;

  // Two bits above the 16-bit magnitude are kept to spot saturation
  localparam int QB    = CENT_W + 2;
  localparam int DSH_W = DEN_W + QB - 1;
  localparam int CNT_W = $clog2(QB);

  logic                   busy;
  logic [CNT_W-1:0]       cnt;
  logic                   neg;
  logic [SUM_W-1:0]       rem;
  logic [DSH_W-1:0]       dsh;
  logic [QB-1:0]          qacc;
  logic [DSH_W-1:0]       rem_x;
  logic [DSH_W-1:0]       diff;
  logic                   ge;
  logic signed [SUM_W-1:0] num_neg;

  assign rem_x   = {{(DSH_W-SUM_W){1'b0}}, rem};
  assign ge      = rem_x >= dsh;
  assign diff    = rem_x - dsh;
  assign num_neg = -num;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        neg  <= num[SUM_W-1];
        rem  <= num[SUM_W-1] ? num_neg : num;
        dsh  <= {den, {(QB-1){1'b0}}};
        qacc <= '0;
      end else if (busy) begin
        if (ge) begin
          rem <= diff[SUM_W-1:0];
        end
        qacc <= {qacc[QB-2:0], ge};
        dsh  <= dsh >> 1;
        cnt  <= cnt + 1'b1;
        if (cnt == CNT_W'(QB-1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    sat = neg ? (qacc > QB'(32768)) : (qacc > QB'(32767));
    if (sat) begin
      quo = neg ? {1'b1, {(CENT_W-1){1'b0}}} : {1'b0, {(CENT_W-1){1'b1}}};
    end else if (neg) begin
      quo = -qacc[CENT_W-1:0];
    end else begin
      quo = qacc[CENT_W-1:0];
    end
  end

endmodule

>>> design/polygon_mass_properties_top.sv
// ----------------------------------------------------------------------------
// polygon_mass_properties_top
// Area, centroid and signed moment of inertia of a polygon streamed in as
// Q8.8 vertices, built round one shared 18x34 multiplier.
// ----------------------------------------------------------------------------
// Vertices are taken one per transfer; in_stall is high whenever the block is
// working. A first vertex that is not flagged last is only stored. Every
// later vertex opens an edge, and one edge runs through 13 sequencer steps
// (12 passes through the shared multiplier for cross product, squared norms,
// the x0*x1 and y0*y1 terms, centroid moments and the two halves of the
// inertia product, then one step to add the halves), an 8-bit-per-cycle
// divide by three and the ST_INER state to fold the inertia term in. A vertex
// flagged last adds the closing edge, then runs two 18-step centroid
// divisions unless the area is zero, and lands the result in the output
// register. A result waiting on out_stall only holds the block at the next
// result, not at the next vertex. Vertices past MAX_VERTICES are dropped,
// though a dropped last vertex still closes the polygon. status: 0 ok,
// 1 zero area (centroid 0), 2 saturated.
// ----------------------------------------------------------------------------
module polygon_mass_properties_top #(
  parameter int MAX_VERTICES = pmp_pkg::DEF_MAX_VERTICES
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] vertex_x,
  input  logic signed [15:0] vertex_y,
  input  logic               last_vertex,
  output logic               out_valid,
  input  logic               out_stall,
  output logic        [46:0] area,
  output logic signed [15:0] centroid_x,
  output logic signed [15:0] centroid_y,
  output logic signed [47:0] inertia,
  output logic        [1:0]  status
);
  import pmp_pkg::*;

  localparam int CNT_W = $clog2(MAX_VERTICES + 1);

  // Last edge micro-step, where the inertia product halves are added, and last divide-by-three step
  localparam logic [3:0] STEP_LAST = 4'd12;
  localparam logic [2:0] DIV3_LAST = 3'd5;

  st_t state, state_next;

  // Polygon state
  logic signed [COORD_W-1:0] first_x, first_y, prev_x, prev_y;
  logic                      have_first;
  logic [CNT_W-1:0]          vert_count;
  logic                      sat_flag;
  logic [AREA_W-1:0]         area_sum;
  logic signed [SUM_W-1:0]   centroid_sum_x, centroid_sum_y, inertia_sum;

  // Current edge: p = (ex0, ey0), c = (ex1, ey1)
  logic signed [COORD_W-1:0] ex0, ey0, ex1, ey1;
  logic                      closing;
  logic                      pend_last;

  // Shared datapath
  logic [3:0]                step;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;
  logic signed [MUL_P_W-1:0] prod;
  logic signed [32:0]        cr;
  logic signed [32:0]        cr_abs;
  logic [31:0]               acr;
  logic                      cr_neg;
  logic signed [34:0]        br;
  logic [SUM_W-1:0]          tt;
  logic [SUM_W-1:0]          tsum;
  logic [AREA_W:0]           area_add;
  logic [AREA_W-1:0]         dv;
  logic [AREA_W-1:0]         dv_next;
  logic [1:0]                r3, r3_next;
  logic [2:0]                div_cnt;
  logic signed [SUM_W-1:0]   prod_x;
  logic signed [SUM_W-1:0]   iner_term;
  sat_res_t                  sx_res, sy_res, si_res;

  // Centroid divider
  logic                      cdiv_start;
  logic signed [SUM_W-1:0]   cdiv_num;
  logic [DEN_W-1:0]          den3;
  logic                      cdiv_done;
  logic signed [CENT_W-1:0]  cdiv_quo;
  logic                      cdiv_sat;
  logic signed [CENT_W-1:0]  cent_x, cent_y;

  logic                      accept;
  logic                      room;
  logic                      out_free;
  logic                      iner_ovf;
  logic signed [47:0]        iner_clamp;
  logic                      area_zero;

  assign accept    = in_valid && (state == ST_IDLE);
  assign room      = vert_count < CNT_W'(MAX_VERTICES);
  assign out_free  = !out_valid || !out_stall;
  assign area_zero = (area_sum == '0);
  assign den3      = {1'b0, area_sum, 1'b0} + {2'b00, area_sum};

  assign mul_p    = mul_a * mul_b;
  assign cr_abs   = cr[32] ? -cr : cr;
  assign area_add = {1'b0, area_sum} + {{(AREA_W-31){1'b0}}, acr};
  assign tsum     = tt + {prod[47:0], 16'b0};
  assign prod_x   = {{(SUM_W-MUL_P_W){prod[MUL_P_W-1]}}, prod};
  assign iner_term = cr_neg ? -{{(SUM_W-AREA_W){1'b0}}, dv}
                            : {{(SUM_W-AREA_W){1'b0}}, dv};

  assign sx_res = sat_add64(centroid_sum_x, prod_x);
  assign sy_res = sat_add64(centroid_sum_y, prod_x);
  assign si_res = sat_add64(inertia_sum, iner_term);

  // Divide by three, eight quotient bits per cycle
  always_comb begin
    logic [2:0] t;
    r3_next = r3;
    dv_next = {dv[AREA_W-9:0], 8'b0};
    for (int i = 0; i < 8; i++) begin
      t = {r3_next, dv[AREA_W-1-i]};
      if (t >= 3'd3) begin
        dv_next[7-i] = 1'b1;
        r3_next      = 2'(t - 3'd3);
      end else begin
        dv_next[7-i] = 1'b0;
        r3_next      = t[1:0];
      end
    end
  end

  // Inertia clamp to 48 bits
  assign iner_ovf   = !((&inertia_sum[SUM_W-1:47]) || !(|inertia_sum[SUM_W-1:47]));
  assign iner_clamp = iner_ovf ? (inertia_sum[SUM_W-1] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}})
                               : inertia_sum[47:0];

  pmp_cdiv u_cdiv (
    .clk   (clk),
    .rst   (rst),
    .start (cdiv_start),
    .num   (cdiv_num),
    .den   (den3),
    .done  (cdiv_done),
    .quo   (cdiv_quo),
    .sat   (cdiv_sat)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (!have_first) begin
            state_next = last_vertex ? ST_EDGE : ST_IDLE;
          end else if (room || last_vertex) begin
            state_next = ST_EDGE;
          end
        end
      end
      ST_EDGE: begin
        if (step == STEP_LAST) state_next = ST_DIV3;
      end
      ST_DIV3: begin
        if (div_cnt == DIV3_LAST) state_next = ST_INER;
      end
      ST_INER: begin
        if (closing) begin
          state_next = area_zero ? ST_DONE : ST_CX;
        end else begin
          state_next = pend_last ? ST_EDGE : ST_IDLE;
        end
      end
      ST_CX: begin
        if (cdiv_done) state_next = ST_CY;
      end
      ST_CY: begin
        if (cdiv_done) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: handshake, multiplier operands, divider start
  always_comb begin
    in_stall   = (state != ST_IDLE);
    cdiv_start = 1'b0;
    cdiv_num   = centroid_sum_x;
    mul_a      = '0;
    mul_b      = '0;
    case (state)
      ST_EDGE: begin
        case (step)
          4'd0: begin
            mul_a = {{2{ex0[15]}}, ex0};
            mul_b = {{18{ey1[15]}}, ey1};
          end
          4'd1: begin
            mul_a = {{2{ey0[15]}}, ey0};
            mul_b = {{18{ex1[15]}}, ex1};
          end
          4'd2: begin
            mul_a = {{2{ex0[15]}}, ex0};
            mul_b = {{18{ex0[15]}}, ex0};
          end
          4'd3: begin
            mul_a = {{2{ey0[15]}}, ey0};
            mul_b = {{18{ey0[15]}}, ey0};
          end
          4'd4: begin
            mul_a = {{2{ex1[15]}}, ex1};
            mul_b = {{18{ex1[15]}}, ex1};
          end
          4'd5: begin
            mul_a = {{2{ey1[15]}}, ey1};
            mul_b = {{18{ey1[15]}}, ey1};
          end
          4'd6: begin
            mul_a = {{2{ex0[15]}}, ex0};
            mul_b = {{18{ex1[15]}}, ex1};
          end
          4'd7: begin
            mul_a = {{2{ey0[15]}}, ey0};
            mul_b = {{18{ey1[15]}}, ey1};
          end
          4'd8: begin
            mul_a = {{2{ex0[15]}}, ex0} + {{2{ex1[15]}}, ex1};
            mul_b = {2'b00, acr};
          end
          4'd9: begin
            mul_a = {{2{ey0[15]}}, ey0} + {{2{ey1[15]}}, ey1};
            mul_b = {2'b00, acr};
          end
          4'd10: begin
            mul_a = {2'b00, acr[15:0]};
            mul_b = br[33:0];
          end
          4'd11: begin
            mul_a = {2'b00, acr[31:16]};
            mul_b = br[33:0];
          end
          default: begin
            mul_a = '0;
            mul_b = '0;
          end
        endcase
      end
      ST_INER: begin
        cdiv_start = closing && !area_zero;
      end
      ST_CX: begin
        cdiv_start = cdiv_done;
        cdiv_num   = centroid_sum_y;
      end
      default: begin
        cdiv_start = 1'b0;
      end
    endcase
  end

  // Registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      have_first     <= 1'b0;
      vert_count     <= '0;
      sat_flag       <= 1'b0;
      area_sum       <= '0;
      centroid_sum_x <= '0;
      centroid_sum_y <= '0;
      inertia_sum    <= '0;
      first_x        <= '0;
      first_y        <= '0;
      prev_x         <= '0;
      prev_y         <= '0;
      closing        <= 1'b0;
      pend_last      <= 1'b0;
      step           <= '0;
      div_cnt        <= '0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      prod  <= mul_p;

      // a new result replaces the old one as it leaves
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          step    <= '0;
          div_cnt <= '0;
          if (accept) begin
            pend_last <= last_vertex;
            if (!have_first) begin
              first_x    <= vertex_x;
              first_y    <= vertex_y;
              prev_x     <= vertex_x;
              prev_y     <= vertex_y;
              have_first <= 1'b1;
              vert_count <= CNT_W'(1);
              ex0        <= vertex_x;
              ey0        <= vertex_y;
              ex1        <= vertex_x;
              ey1        <= vertex_y;
              closing    <= 1'b1;
            end else if (room) begin
              ex0        <= prev_x;
              ey0        <= prev_y;
              ex1        <= vertex_x;
              ey1        <= vertex_y;
              prev_x     <= vertex_x;
              prev_y     <= vertex_y;
              vert_count <= vert_count + 1'b1;
              closing    <= 1'b0;
            end else begin
              // vertex dropped; a last one still closes back to the first
              ex0     <= prev_x;
              ey0     <= prev_y;
              ex1     <= first_x;
              ey1     <= first_y;
              closing <= 1'b1;
            end
          end
        end
        ST_EDGE: begin
          step <= step + 1'b1;
          case (step)
            4'd1: cr <= prod[32:0];
            4'd2: cr <= cr - prod[32:0];
            4'd3: begin
              br     <= prod[34:0];
              acr    <= cr_abs[31:0];
              cr_neg <= cr[32];
            end
            4'd4: begin
              br <= br + prod[34:0];
              if (area_add[AREA_W]) begin
                area_sum <= '1;
                sat_flag <= 1'b1;
              end else begin
                area_sum <= area_add[AREA_W-1:0];
              end
            end
            4'd5, 4'd6, 4'd7, 4'd8: br <= br + prod[34:0];
            4'd9: begin
              centroid_sum_x <= sx_res.val;
              if (sx_res.ovf) sat_flag <= 1'b1;
            end
            4'd10: begin
              centroid_sum_y <= sy_res.val;
              if (sy_res.ovf) sat_flag <= 1'b1;
            end
            4'd11: tt <= {{(SUM_W-MUL_P_W){1'b0}}, prod};
            4'd12: begin
              // scale 12 * 2^16: drop 18 bits here, divide by three next
              dv      <= {2'b00, tsum[SUM_W-1:18]};
              r3      <= 2'd0;
              div_cnt <= '0;
            end
            default: begin
            end
          endcase
        end
        ST_DIV3: begin
          dv      <= dv_next;
          r3      <= r3_next;
          div_cnt <= div_cnt + 1'b1;
        end
        ST_INER: begin
          inertia_sum <= si_res.val;
          if (si_res.ovf) sat_flag <= 1'b1;
          step <= '0;
          if (!closing && pend_last) begin
            ex0     <= prev_x;
            ey0     <= prev_y;
            ex1     <= first_x;
            ey1     <= first_y;
            closing <= 1'b1;
          end
        end
        ST_CX: begin
          if (cdiv_done) begin
            cent_x <= cdiv_quo;
            if (cdiv_sat) sat_flag <= 1'b1;
          end
        end
        ST_CY: begin
          if (cdiv_done) begin
            cent_y <= cdiv_quo;
            if (cdiv_sat) sat_flag <= 1'b1;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            area       <= area_sum[AREA_W-1:1];
            centroid_x <= area_zero ? '0 : cent_x;
            centroid_y <= area_zero ? '0 : cent_y;
            inertia    <= iner_clamp;
            if (area_zero) begin
              status <= STATUS_ZERO;
            end else if (sat_flag || iner_ovf) begin
              status <= STATUS_SAT;
            end else begin
              status <= STATUS_OK;
            end
            // start afresh for the next polygon
            have_first     <= 1'b0;
            vert_count     <= '0;
            sat_flag       <= 1'b0;
            area_sum       <= '0;
            centroid_sum_x <= '0;
            centroid_sum_y <= '0;
            inertia_sum    <= '0;
            first_x        <= '0;
            first_y        <= '0;
            prev_x         <= '0;
            prev_y         <= '0;
            closing        <= 1'b0;
            pend_last      <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
